### rtl/bpseq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buzzer pattern sequencer package
// Shared widths, command codes, segment field helpers and types.
// ----------------------------------------------------------------------------
package bpseq_pkg;

    localparam int TIME_BITS = 8;
    localparam int SEG_COUNT = 8;
    localparam int SEG_W     = $clog2(SEG_COUNT);
    localparam int REG_W     = 32;

    localparam logic [7:0]       PAUSE_END = 8'hff;
    localparam logic [REG_W-1:0] SEG_RESET = 32'hff00_0000;

    // Command codes carried in the func field.
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_ON    = 2'd1;
    localparam logic [1:0] FUNC_OFF   = 2'd2;
    localparam logic [1:0] FUNC_PAUSE = 2'd3;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [SEG_W-1:0]     t_seg_idx;
    typedef logic [REG_W-1:0]     t_seg;
    typedef t_seg                 t_seg_table [SEG_COUNT];

    function automatic logic [7:0] seg_byte(input t_seg seg, input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = seg[7:0];
            2'd1:    b = seg[15:8];
            2'd2:    b = seg[23:16];
            default: b = seg[31:24];
        endcase
        return b;
    endfunction

    // Time fields are fitted to the counter width when they are loaded.
    function automatic t_time to_time(input logic [7:0] b);
        return t_time'(b);
    endfunction

endpackage

### rtl/bpseq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buzzer pattern sequencer channels
// Valid/ready interfaces for the command and the result channel.
// ----------------------------------------------------------------------------
interface bpseq_in_if;
    import bpseq_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    t_seg_idx   start_segment;

    modport source (output valid, output func, output start_segment, input ready);
    modport sink   (input valid, input func, input start_segment, output ready);
endinterface

interface bpseq_out_if;
    import bpseq_pkg::*;
    logic     valid;
    logic     ready;
    logic     buzzer_level;
    t_seg_idx current_segment;

    modport source (output valid, output buzzer_level, output current_segment, input ready);
    modport sink   (input valid, input buzzer_level, input current_segment, output ready);
endinterface

### rtl/buzzer_pattern_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buzzer pattern sequencer
// Steps a buzzer pin through a table of eight on/off/pulse/pause segments.
//
//   Channel  Direction  Payload                          Handshake
//   s_in     in         func, start_segment              valid/ready
//   m_out    out        buzzer_level, current_segment    valid/ready
//   cfg      in         i_cfg_idx, i_cfg_wdata           i_cfg_we, no wait
//
// Each command item updates the state combinationally and its result item
// appears in the result register on the following cycle; one item per cycle
// is sustained while m_out.ready is high. There is one result register:
// s_in.ready drops only while a result is held and m_out.ready is low. Reset
// is synchronous and active low; segments reset to 0xFF000000 and the pin is off.
// ----------------------------------------------------------------------------
module buzzer_pattern_sequencer_top
    import bpseq_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  t_seg_idx      i_cfg_idx,
    input  t_seg          i_cfg_wdata,
    bpseq_in_if.sink      s_in,
    bpseq_out_if.source   m_out
);

    t_seg_table segs;

    bpseq_seg_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_segs      (segs)
    );

    bpseq_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_segs            (segs),
        .i_in_valid        (s_in.valid),
        .o_in_ready        (s_in.ready),
        .i_func            (s_in.func),
        .i_start_segment   (s_in.start_segment),
        .o_out_valid       (m_out.valid),
        .i_out_ready       (m_out.ready),
        .o_buzzer_level    (m_out.buzzer_level),
        .o_current_segment (m_out.current_segment)
    );

endmodule

### rtl/bpseq_seg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buzzer pattern segment registers
// Eight 32-bit pattern segments written through a plain write port.
// ----------------------------------------------------------------------------
module bpseq_seg_regs
    import bpseq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  t_seg_idx   i_cfg_idx,
    input  t_seg       i_cfg_wdata,
    output t_seg_table o_segs
);

    t_seg_table r_segs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SEG_COUNT; i++) begin
                r_segs[i] <= SEG_RESET;
            end
        end else if (i_cfg_we) begin
            r_segs[i_cfg_idx] <= i_cfg_wdata;
        end
    end

    assign o_segs = r_segs;

endmodule

### rtl/bpseq_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buzzer pattern sequencer core
// Sequencer state, combinational command update and the result register.
// ----------------------------------------------------------------------------
module bpseq_core
    import bpseq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_seg_table i_segs,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_func,
    input  t_seg_idx   i_start_segment,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_buzzer_level,
    output t_seg_idx   o_current_segment
);

    t_time      r_on_rem,  n_on_rem;
    t_time      r_off_rem, n_off_rem;
    t_time      r_pau_rem, n_pau_rem;
    logic [7:0] r_pulses,  n_pulses;
    logic [7:0] r_pend,    n_pend;
    t_seg_idx   r_seg_idx, n_seg_idx;
    logic       r_pin,     n_pin;

    logic       r_out_valid;
    logic       r_out_level;
    t_seg_idx   r_out_seg;

    logic       accept;
    t_seg       cur_seg;
    t_seg       load_seg;
    t_time      off_dec;
    logic [7:0] pulses_dec;

    // The result register frees up in the same cycle it is taken.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign cur_seg    = i_segs[r_seg_idx];
    assign off_dec    = r_off_rem - 1'b1;
    assign pulses_dec = r_pulses - 8'd1;

    always_comb begin
        n_on_rem  = r_on_rem;
        n_off_rem = r_off_rem;
        n_pau_rem = r_pau_rem;
        n_pulses  = r_pulses;
        n_pend    = r_pend;
        n_seg_idx = r_seg_idx;
        n_pin     = r_pin;
        load_seg  = cur_seg;
        case (i_func)
            FUNC_START: begin
                load_seg  = i_segs[i_start_segment];
                n_seg_idx = i_start_segment;
                n_pin     = 1'b1;
                n_on_rem  = to_time(seg_byte(load_seg, 2'd0));
                n_pulses  = seg_byte(load_seg, 2'd2);
                n_pend    = seg_byte(load_seg, 2'd3);
            end
            FUNC_ON: begin
                if (r_on_rem != '0) begin
                    n_on_rem = r_on_rem - 1'b1;
                    if (n_on_rem == '0) begin
                        n_pin     = 1'b0;
                        n_off_rem = to_time(seg_byte(cur_seg, 2'd1));
                    end
                end
            end
            FUNC_OFF: begin
                if (r_off_rem != '0) begin
                    n_off_rem = off_dec;
                    if (off_dec == '0) begin
                        n_pulses = pulses_dec;
                        if (pulses_dec != 8'd0) begin
                            n_on_rem = to_time(seg_byte(cur_seg, 2'd0));
                            n_pin    = 1'b1;
                        end else if (r_pend != PAUSE_END) begin
                            n_seg_idx = r_seg_idx + 1'b1;
                            n_pau_rem = to_time(r_pend);
                        end
                    end
                end
            end
            default: begin
                if (r_pau_rem != '0) begin
                    n_pau_rem = r_pau_rem - 1'b1;
                    // The index already points at the next segment here.
                    if (n_pau_rem == '0) begin
                        n_pin    = 1'b1;
                        n_on_rem = to_time(seg_byte(cur_seg, 2'd0));
                        n_pulses = seg_byte(cur_seg, 2'd2);
                        n_pend   = seg_byte(cur_seg, 2'd3);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_rem    <= '0;
            r_off_rem   <= '0;
            r_pau_rem   <= '0;
            r_pulses    <= '0;
            r_pend      <= '0;
            r_seg_idx   <= '0;
            r_pin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_on_rem  <= n_on_rem;
                r_off_rem <= n_off_rem;
                r_pau_rem <= n_pau_rem;
                r_pulses  <= n_pulses;
                r_pend    <= n_pend;
                r_seg_idx <= n_seg_idx;
                r_pin     <= n_pin;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_level <= n_pin;
            r_out_seg   <= n_seg_idx;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_buzzer_level    = r_out_level;
    assign o_current_segment = r_out_seg;

endmodule

### rtl/bpseq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buzzer pattern sequencer checker
// Port-level checks on item flow and start behavior, bound to the top level.
// ----------------------------------------------------------------------------
module bpseq_checker
    import bpseq_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_func,
    input t_seg_idx   i_start_segment,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_level,
    input t_seg_idx   i_segment
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // A held result must stay until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_level)
                                        && $stable(i_segment))
        else $error("result item changed while stalled");

    // Every accepted item yields a result on the next cycle.
    a_acc_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> i_out_valid)
        else $error("accepted item produced no result");

    // The block can always take an item when no result is pending.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

    // A start sounds the pin on the requested segment.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_func == FUNC_START |=>
            i_level && i_segment == $past(i_start_segment))
        else $error("start item gave wrong result");

endmodule

bind buzzer_pattern_sequencer_top bpseq_checker u_bpseq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (s_in.valid),
    .i_in_ready      (s_in.ready),
    .i_func          (s_in.func),
    .i_start_segment (s_in.start_segment),
    .i_out_valid     (m_out.valid),
    .i_out_ready     (m_out.ready),
    .i_level         (m_out.buzzer_level),
    .i_segment       (m_out.current_segment)
);
